>>> src/ngsr_pkg.sv
// Package for the n-gram sorted run lookup block.
// Holds the shared types, action codes and register indexes; depends on nothing.
package ngsr_pkg;

   localparam int DATA_W = 16;

   localparam logic [2:0] ACT_PAIR_START = 3'd0;
   localparam logic [2:0] ACT_PAIR_ENTRY = 3'd1;
   localparam logic [2:0] ACT_TRI_START  = 3'd2;
   localparam logic [2:0] ACT_TRI_ENTRY  = 3'd3;
   localparam logic [2:0] ACT_BIGRAM     = 3'd4;
   localparam logic [2:0] ACT_TRIGRAM    = 3'd5;

   localparam logic [1:0] REG_WORD_COUNT = 2'd0;
   localparam logic [1:0] REG_SUCC_COUNT = 2'd1;
   localparam logic [1:0] REG_TRI_COUNT  = 2'd2;
   localparam logic [1:0] REG_START_ID   = 2'd3;

   typedef struct packed {
      logic [12:0] word_count;
      logic [14:0] successor_count;
      logic [14:0] trigram_count;
      logic [15:0] sentence_start_id;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic write;
      logic level;
      logic second;
      logic take_begin;
      logic clamp;
      logic probe;
      logic compare;
      logic save_pos;
      logic record;
      logic clear_result;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       ctx_miss;
      logic       tri_off;
      logic       run_empty;
      logic       eq;
      logic       more;
   } status_type;

endpackage

>>> src/ngsr_ram.sv
// Generic single-port RAM with a registered read port.
// Stands alone; every table store of the lookup block is one instance.
module ngsr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                        wdata,
   output logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

>>> src/ngsr_csr.sv
// Configuration registers of the lookup block behind an APB-style port.
// Depends on ngsr_pkg for the register indexes and the configuration struct.
module ngsr_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [3:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready,
   output ngsr_pkg::cfg_type cfg
);
   import ngsr_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr;

   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_paddr[3:2])
            REG_WORD_COUNT: cfg_in.word_count = csr_pwdata[12:0];
            REG_SUCC_COUNT: cfg_in.successor_count = csr_pwdata[14:0];
            REG_TRI_COUNT:  cfg_in.trigram_count = csr_pwdata[14:0];
            REG_START_ID:   cfg_in.sentence_start_id = csr_pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_WORD_COUNT: csr_prdata = {19'd0, cfg_ff.word_count};
         REG_SUCC_COUNT: csr_prdata = {17'd0, cfg_ff.successor_count};
         REG_TRI_COUNT:  csr_prdata = {17'd0, cfg_ff.trigram_count};
         REG_START_ID:   csr_prdata = {16'd0, cfg_ff.sentence_start_id};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{word_count: 13'd0, successor_count: 15'd0,
                    trigram_count: 15'd0, sentence_start_id: 16'hFFFF};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

>>> src/ngsr_dp.sv
// Datapath of the lookup block: item registers, the four table RAMs, run clamping
// and the shared binary search registers. Depends on ngsr_pkg and ngsr_ram.
module ngsr_dp #(
   parameter int MAX_WORDS   = 4096,
   parameter int MAX_PAIRS   = 16384,
   parameter int MAX_TRIPLES = 16384,
   parameter int WORD_BITS   = 16
) (
   input  logic                  clock,
   input  ngsr_pkg::cfg_type     cfg,
   input  ngsr_pkg::cmd_type     cmd,
   input  logic [2:0]            req_action,
   input  logic [14:0]           req_load_index,
   input  logic [15:0]           req_load_data,
   input  logic [7:0]            req_load_value,
   input  logic [15:0]           req_word_two_back,
   input  logic [15:0]           req_word_one_back,
   input  logic [15:0]           req_word_current,
   output ngsr_pkg::status_type  status,
   output logic                  found,
   output logic [7:0]            value_byte
);
   import ngsr_pkg::*;

   localparam int WB = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
   localparam logic [DATA_W-1:0] WORD_MASK = DATA_W'((32'h1 << WB) - 32'h1);
   localparam int PS_DEPTH = MAX_WORDS + 2;
   localparam int TS_DEPTH = MAX_PAIRS + 1;
   localparam int PS_AW = $clog2(PS_DEPTH);
   localparam int TS_AW = $clog2(TS_DEPTH);
   localparam int PW_AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int TW_AW = (MAX_TRIPLES > 1) ? $clog2(MAX_TRIPLES) : 1;
   localparam logic [DATA_W-1:0] WORD_CAP = DATA_W'(MAX_WORDS);
   localparam logic [DATA_W-1:0] PAIR_CAP = DATA_W'(MAX_PAIRS);
   localparam logic [DATA_W-1:0] TRI_CAP  = DATA_W'(MAX_TRIPLES);

   logic [2:0]        action_ff;
   logic [14:0]       idx_ff;
   logic [15:0]       data_ff, w2_ff, w1_ff, w0_ff;
   logic [7:0]        val_ff;
   logic [DATA_W-1:0] begin_ff, lo_ff, hi_ff, mid_ff, pos_ff;
   logic              found_ff;
   logic [7:0]        value_ff;

   logic [31:0]       idx_wide;
   logic [DATA_W-1:0] n_pair, wc, tn, ctx, list, key, base, base_addr, cap;
   logic [DATA_W-1:0] start_rd, clamp_b, clamp_e, mid, word_ext, mid_next;
   logic [15:0]       ps_rdata, ts_rdata;
   logic [WB+7:0]     pw_rdata, tw_rdata;
   logic              ps_we, pw_we, ts_we, tw_we, less;

   assign idx_wide = {17'd0, idx_ff};

   assign n_pair = ({1'b0, cfg.successor_count} > PAIR_CAP) ? PAIR_CAP
                                                            : {1'b0, cfg.successor_count};
   assign tn = ({1'b0, cfg.trigram_count} > TRI_CAP) ? TRI_CAP : {1'b0, cfg.trigram_count};
   assign wc = ({3'd0, cfg.word_count} > WORD_CAP) ? WORD_CAP : {3'd0, cfg.word_count};

   assign ctx = (action_ff == ACT_TRIGRAM) ? w2_ff : w1_ff;
   assign list = (ctx == cfg.sentence_start_id) ? wc : ctx;
   assign key = (cmd.level ? w0_ff : ((action_ff == ACT_TRIGRAM) ? w1_ff : w0_ff)) & WORD_MASK;
   assign base = cmd.level ? pos_ff : list;
   assign base_addr = cmd.second ? base + DATA_W'(1) : base;
   assign cap = cmd.level ? tn : n_pair;

   assign start_rd = cmd.level ? ts_rdata : ps_rdata;
   assign clamp_b = (begin_ff > cap) ? cap : begin_ff;
   assign clamp_e = (start_rd > cap) ? cap : start_rd;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign mid_next = mid_ff + DATA_W'(1);
   assign word_ext = cmd.level ? DATA_W'(tw_rdata[WB-1:0]) : DATA_W'(pw_rdata[WB-1:0]);
   assign less = word_ext < key;

   assign status.action = action_ff;
   assign status.ctx_miss = (n_pair == '0) || (list > wc);
   assign status.tri_off = (tn == '0);
   assign status.run_empty = (clamp_e <= clamp_b);
   assign status.eq = (word_ext == key);
   assign status.more = less ? (mid_next < hi_ff) : (lo_ff < mid_ff);

   assign ps_we = cmd.write && (action_ff == ACT_PAIR_START) && (idx_wide < 32'(PS_DEPTH));
   assign ts_we = cmd.write && (action_ff == ACT_TRI_START) && (idx_wide < 32'(TS_DEPTH));
   assign pw_we = cmd.write && (action_ff == ACT_PAIR_ENTRY) && (idx_wide < 32'(MAX_PAIRS));
   assign tw_we = cmd.write && (action_ff == ACT_TRI_ENTRY) && (idx_wide < 32'(MAX_TRIPLES));

   ngsr_ram #(.WIDTH(16), .DEPTH(PS_DEPTH)) u_pair_starts (
      .clock(clock), .we(ps_we),
      .addr(cmd.write ? idx_wide[PS_AW-1:0] : PS_AW'(base_addr)),
      .wdata(data_ff), .rdata(ps_rdata));

   ngsr_ram #(.WIDTH(16), .DEPTH(TS_DEPTH)) u_triple_starts (
      .clock(clock), .we(ts_we),
      .addr(cmd.write ? idx_wide[TS_AW-1:0] : TS_AW'(base_addr)),
      .wdata(data_ff), .rdata(ts_rdata));

   ngsr_ram #(.WIDTH(WB + 8), .DEPTH(MAX_PAIRS)) u_pair_entries (
      .clock(clock), .we(pw_we),
      .addr(cmd.write ? idx_wide[PW_AW-1:0] : PW_AW'(mid)),
      .wdata({val_ff, data_ff[WB-1:0]}), .rdata(pw_rdata));

   ngsr_ram #(.WIDTH(WB + 8), .DEPTH(MAX_TRIPLES)) u_triple_entries (
      .clock(clock), .we(tw_we),
      .addr(cmd.write ? idx_wide[TW_AW-1:0] : TW_AW'(mid)),
      .wdata({val_ff, data_ff[WB-1:0]}), .rdata(tw_rdata));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         idx_ff <= req_load_index;
         data_ff <= req_load_data;
         val_ff <= req_load_value;
         w2_ff <= req_word_two_back;
         w1_ff <= req_word_one_back;
         w0_ff <= req_word_current;
      end
      if (cmd.take_begin) begin
         begin_ff <= start_rd;
      end
      if (cmd.clamp) begin
         lo_ff <= clamp_b;
         hi_ff <= clamp_e;
      end
      if (cmd.probe) begin
         mid_ff <= mid;
      end
      if (cmd.compare) begin
         if (less) begin
            lo_ff <= mid_next;
         end else begin
            hi_ff <= mid_ff;
         end
      end
      if (cmd.save_pos) begin
         pos_ff <= mid_ff;
      end
      if (cmd.clear_result) begin
         found_ff <= 1'b0;
         value_ff <= 8'd0;
      end else if (cmd.record) begin
         found_ff <= 1'b1;
         value_ff <= cmd.level ? tw_rdata[WB+7:WB] : pw_rdata[WB+7:WB];
      end
   end

   assign found = found_ff;
   assign value_byte = value_ff;
endmodule

>>> src/ngsr_ctrl.sv
// Controller of the lookup block: sequences loads, run reads and search probes.
// Depends on ngsr_pkg for the command and status structs.
module ngsr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  ngsr_pkg::status_type status,
   output ngsr_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);
   import ngsr_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_RUN0   = 3'd2;
   localparam logic [2:0] S_RUN1   = 3'd3;
   localparam logic [2:0] S_RUN2   = 3'd4;
   localparam logic [2:0] S_PROBE  = 3'd5;
   localparam logic [2:0] S_CMP    = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       level_ff, level_in;
   logic       final_level;

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign final_level = level_ff || (status.action == ACT_BIGRAM);

   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      cmd = '0;
      cmd.level = level_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            level_in = 1'b0;
            case (status.action)
               ACT_PAIR_START, ACT_PAIR_ENTRY, ACT_TRI_START, ACT_TRI_ENTRY: begin
                  cmd.write = 1'b1;
                  state_in = S_IDLE;
               end
               ACT_BIGRAM, ACT_TRIGRAM: begin
                  cmd.clear_result = 1'b1;
                  if (status.ctx_miss ||
                      (status.action == ACT_TRIGRAM && status.tri_off)) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_RUN0;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_RUN0: state_in = S_RUN1;
         S_RUN1: begin
            cmd.take_begin = 1'b1;
            cmd.second = 1'b1;
            state_in = S_RUN2;
         end
         S_RUN2: begin
            cmd.clamp = 1'b1;
            state_in = status.run_empty ? S_DONE : S_PROBE;
         end
         S_PROBE: begin
            cmd.probe = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (status.eq) begin
               if (final_level) begin
                  cmd.record = 1'b1;
                  state_in = S_DONE;
               end else begin
                  cmd.save_pos = 1'b1;
                  level_in = 1'b1;
                  state_in = S_RUN0;
               end
            end else begin
               cmd.compare = 1'b1;
               state_in = status.more ? S_PROBE : S_DONE;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         level_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
      end
   end

`ifndef SYNTH
   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_DECODE)) else $error("accept did not decode");
   a_done_returns: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy) else $error("result strobe not single");
   a_write_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (state_ff == S_DECODE) && !status.action[2])
      else $error("store write outside load decode");
   a_record_final: assert property (@(posedge clock) disable iff (reset)
      cmd.record |-> (state_ff == S_CMP) && status.eq) else $error("record without match");
`endif
endmodule

>>> src/ngram_sorted_run_lookup.sv
// Top level of the n-gram sorted run lookup block.
// Depends on ngsr_pkg, ngsr_csr, ngsr_ctrl, ngsr_dp and ngsr_ram.
//
// A word is accepted when start is high and busy is low; busy stays high until the
// block can take the next word. A load writes its table in the decode state. A bigram
// query reads the run bounds, then runs a binary search of P probes (at most
// 1 + log2 of the run length, 15 for 16384 entries), and a trigram query adds a second
// run read and search. Every table is a single-port RAM with a registered read, so each
// probe has a read state followed by a compare state. The result word shows on
// the rsp_ ports for one cycle with rsp_valid and cannot be held off.
module ngram_sorted_run_lookup #(
   parameter int MAX_WORDS   = 4096,
   parameter int MAX_PAIRS   = 16384,
   parameter int MAX_TRIPLES = 16384,
   parameter int WORD_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [14:0] req_load_index,
   input  logic [15:0] req_load_data,
   input  logic [7:0]  req_load_value,
   input  logic [15:0] req_word_two_back,
   input  logic [15:0] req_word_one_back,
   input  logic [15:0] req_word_current,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [7:0]  rsp_value_byte,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ngsr_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   ngsr_csr u_csr (
      .clock(clock), .reset(reset), .csr_psel(csr_psel), .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready), .cfg(cfg));

   ngsr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .status(status), .cmd(cmd),
      .busy(busy), .rsp_valid(rsp_valid));

   ngsr_dp #(
      .MAX_WORDS(MAX_WORDS), .MAX_PAIRS(MAX_PAIRS),
      .MAX_TRIPLES(MAX_TRIPLES), .WORD_BITS(WORD_BITS)
   ) u_dp (
      .clock(clock), .cfg(cfg), .cmd(cmd), .req_action(req_action),
      .req_load_index(req_load_index), .req_load_data(req_load_data),
      .req_load_value(req_load_value), .req_word_two_back(req_word_two_back),
      .req_word_one_back(req_word_one_back), .req_word_current(req_word_current),
      .status(status), .found(rsp_found), .value_byte(rsp_value_byte));
endmodule

>>> tb/ngram_sorted_run_lookup_test.sv
// Self-checking test of the n-gram sorted run lookup block.
// Loads a sorted two-level table, issues bigram and trigram queries against its own
// mirror of the tables, and checks every result word. Depends on ngsr_pkg and the RTL.
`timescale 1ns / 100ps

module ngram_sorted_run_lookup_test;
   import ngsr_pkg::*;

   localparam int PAIR_START_DEPTH = 4098;
   localparam int PAIR_DEPTH       = 16384;
   localparam int TRI_START_DEPTH  = 16385;
   localparam int TRI_DEPTH        = 16384;
   localparam int WORD_LIMIT       = 4096;
   localparam int SETTLE_CYCLES    = 80;
   localparam int STALL_LIMIT      = 20000;
   localparam int TABLE_WORDS      = 12;
   localparam logic [2:0] ACT_SPARE_A = 3'd6;
   localparam logic [2:0] ACT_SPARE_B = 3'd7;

   typedef struct {
      logic [2:0]  action;
      logic [14:0] index;
      logic [15:0] data;
      logic [7:0]  value;
      logic [15:0] two_back;
      logic [15:0] one_back;
      logic [15:0] current;
   } lookup_word_type;

   typedef struct {
      logic       found;
      logic [7:0] value;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_action;
   logic [14:0] req_load_index;
   logic [15:0] req_load_data;
   logic [7:0]  req_load_value;
   logic [15:0] req_word_two_back;
   logic [15:0] req_word_one_back;
   logic [15:0] req_word_current;
   logic        rsp_valid;
   logic        rsp_found;
   logic [7:0]  rsp_value_byte;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [15:0] pair_start [PAIR_START_DEPTH];
   bit          pair_start_ok [PAIR_START_DEPTH];
   logic [15:0] pair_word [PAIR_DEPTH];
   logic [7:0]  pair_value [PAIR_DEPTH];
   bit          pair_ok [PAIR_DEPTH];
   int unsigned pair_owner [PAIR_DEPTH];
   logic [15:0] tri_start [TRI_START_DEPTH];
   bit          tri_start_ok [TRI_START_DEPTH];
   logic [15:0] tri_word [TRI_DEPTH];
   logic [7:0]  tri_value [TRI_DEPTH];
   bit          tri_ok [TRI_DEPTH];

   int unsigned cfg_words;
   int unsigned cfg_succ;
   int unsigned cfg_tri;
   logic [15:0] cfg_start_id;

   int unsigned pair_total;
   int unsigned triple_total;
   answer_type  pending_answers[$];
   int          mismatches;
   int          stall_cycles;
   bit          quiet;

   ngram_sorted_run_lookup u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_load_index(req_load_index),
      .req_load_data(req_load_data), .req_load_value(req_load_value),
      .req_word_two_back(req_word_two_back), .req_word_one_back(req_word_one_back),
      .req_word_current(req_word_current),
      .rsp_valid(rsp_valid), .rsp_found(rsp_found), .rsp_value_byte(rsp_value_byte),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_run(input int unsigned b, input int unsigned e,
                                             input int unsigned n, output int unsigned first);
      if (b > n) b = n;
      if (e > n) e = n;
      if (e < b) e = b;
      first = b;
      return e - b;
   endfunction

   function automatic bit search_run(input bit is_triple, input int unsigned first,
                                     input int unsigned len, input logic [15:0] key,
                                     output int unsigned pos, inout bit bad);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      logic [15:0] w;
      bit          known;
      lo = first;
      hi = first + len;
      pos = 0;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (is_triple) begin
            w = tri_word[mid];
            known = tri_ok[mid];
         end else begin
            w = pair_word[mid];
            known = pair_ok[mid];
         end
         if (!known) bad = 1'b1;
         if (w == key) begin
            pos = mid;
            return 1'b1;
         end
         if (w < key) lo = mid + 1;
         else hi = mid;
      end
      return 1'b0;
   endfunction

   function automatic bit find_pair(input logic [15:0] ctx, input logic [15:0] word,
                                    output int unsigned pos, inout bit bad);
      int unsigned n;
      int unsigned wc;
      int unsigned list;
      int unsigned first;
      int unsigned len;
      n = cfg_succ > PAIR_DEPTH ? PAIR_DEPTH : cfg_succ;
      wc = cfg_words > WORD_LIMIT ? WORD_LIMIT : cfg_words;
      pos = 0;
      if (n == 0) return 1'b0;
      list = (ctx == cfg_start_id) ? wc : ctx;
      if (list > wc) return 1'b0;
      if (!pair_start_ok[list] || !pair_start_ok[list + 1]) bad = 1'b1;
      len = clamp_run(pair_start[list], pair_start[list + 1], n, first);
      if (len == 0) return 1'b0;
      return search_run(1'b0, first, len, word, pos, bad);
   endfunction

   function automatic answer_type predict_answer(input lookup_word_type w, inout bit bad);
      answer_type  a;
      int unsigned pos;
      int unsigned pair;
      int unsigned tn;
      int unsigned pn;
      int unsigned first;
      int unsigned len;
      a.found = 1'b0;
      a.value = 8'd0;
      if (w.action == ACT_BIGRAM) begin
         if (find_pair(w.one_back, w.current, pos, bad)) begin
            a.found = 1'b1;
            a.value = pair_value[pos];
         end
      end else begin
         tn = cfg_tri > TRI_DEPTH ? TRI_DEPTH : cfg_tri;
         pn = cfg_succ > PAIR_DEPTH ? PAIR_DEPTH : cfg_succ;
         if (tn != 0 && find_pair(w.two_back, w.one_back, pair, bad) && pair < pn) begin
            if (!tri_start_ok[pair] || !tri_start_ok[pair + 1]) bad = 1'b1;
            len = clamp_run(tri_start[pair], tri_start[pair + 1], tn, first);
            if (len != 0 && search_run(1'b1, first, len, w.current, pos, bad)) begin
               a.found = 1'b1;
               a.value = tri_value[pos];
            end
         end
      end
      return a;
   endfunction

   function automatic void apply_load(input lookup_word_type w);
      case (w.action)
         ACT_PAIR_START: if (w.index < PAIR_START_DEPTH) begin
            pair_start[w.index] = w.data;
            pair_start_ok[w.index] = 1'b1;
         end
         ACT_PAIR_ENTRY: if (w.index < PAIR_DEPTH) begin
            pair_word[w.index] = w.data;
            pair_value[w.index] = w.value;
            pair_ok[w.index] = 1'b1;
         end
         ACT_TRI_START: if (w.index < TRI_START_DEPTH) begin
            tri_start[w.index] = w.data;
            tri_start_ok[w.index] = 1'b1;
         end
         ACT_TRI_ENTRY: if (w.index < TRI_DEPTH) begin
            tri_word[w.index] = w.data;
            tri_value[w.index] = w.value;
            tri_ok[w.index] = 1'b1;
         end
         default: ;
      endcase
   endfunction

   task automatic send_word(input lookup_word_type w);
      bit bad;
      @(posedge clock);
      while (!quiet && $urandom_range(99) < 26) @(posedge clock);
      start <= 1'b1;
      req_action <= w.action;
      req_load_index <= w.index;
      req_load_data <= w.data;
      req_load_value <= w.value;
      req_word_two_back <= w.two_back;
      req_word_one_back <= w.one_back;
      req_word_current <= w.current;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      if (w.action == ACT_BIGRAM || w.action == ACT_TRIGRAM) begin
         bad = 1'b0;
         pending_answers.push_back(predict_answer(w, bad));
      end else begin
         apply_load(w);
      end
   endtask

   function automatic lookup_word_type make_word(input logic [2:0] action);
      lookup_word_type w;
      w.action = action;
      w.index = 15'($urandom);
      w.data = 16'($urandom);
      w.value = 8'($urandom);
      w.two_back = 16'($urandom);
      w.one_back = 16'($urandom);
      w.current = 16'($urandom);
      return w;
   endfunction

   task automatic load_entry(input logic [2:0] action, input int unsigned index,
                             input logic [15:0] data, input logic [7:0] value);
      lookup_word_type w;
      w = make_word(action);
      w.index = 15'(index);
      w.data = data;
      w.value = value;
      send_word(w);
   endtask

   task automatic query(input logic [2:0] action, input logic [15:0] two_back,
                        input logic [15:0] one_back, input logic [15:0] current);
      lookup_word_type w;
      w = make_word(action);
      w.two_back = two_back;
      w.one_back = one_back;
      w.current = current;
      send_word(w);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         REG_WORD_COUNT: cfg_words = value & 32'h1FFF;
         REG_SUCC_COUNT: cfg_succ = value & 32'h7FFF;
         REG_TRI_COUNT:  cfg_tri = value & 32'h7FFF;
         REG_START_ID:   cfg_start_id = value[15:0];
         default: ;
      endcase
   endtask

   task automatic drain;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic build_table(input int unsigned words);
      int unsigned p;
      int unsigned t;
      int unsigned list;
      int unsigned k;
      int unsigned j;
      int unsigned runlen;
      int unsigned trilen;
      logic [15:0] w;
      logic [15:0] tw;
      p = 0;
      t = 0;
      for (list = 0; list <= words; list++) begin
         load_entry(ACT_PAIR_START, list, 16'(p), 8'd0);
         runlen = $urandom_range(0, 4);
         w = 16'($urandom_range(0, 3));
         for (k = 0; k < runlen; k++) begin
            load_entry(ACT_PAIR_ENTRY, p, w, 8'($urandom));
            pair_owner[p] = list;
            load_entry(ACT_TRI_START, p, 16'(t), 8'd0);
            trilen = $urandom_range(0, 3);
            tw = 16'($urandom_range(0, 3));
            for (j = 0; j < trilen; j++) begin
               load_entry(ACT_TRI_ENTRY, t, tw, 8'($urandom));
               tw += 16'($urandom_range(1, 5000));
               t++;
            end
            w += 16'($urandom_range(1, 5000));
            p++;
         end
      end
      load_entry(ACT_PAIR_START, words + 1, 16'(p), 8'd0);
      load_entry(ACT_TRI_START, p, 16'(t), 8'd0);
      pair_total = p;
      triple_total = t;
   endtask

   task automatic random_item;
      lookup_word_type w;
      int unsigned     p;
      int unsigned     k;
      int unsigned     tries;
      bit              bad;
      answer_type      scratch;
      if ($urandom_range(99) < 15) begin
         w = make_word(3'($urandom_range(0, 3)));
         if ($urandom_range(1)) w.index = 15'($urandom_range(0, pair_total + 2));
         if ($urandom_range(1)) w.data = 16'($urandom_range(0, pair_total + 3));
         send_word(w);
         return;
      end
      for (tries = 0; tries < 20; tries++) begin
         w = make_word($urandom_range(1) ? ACT_TRIGRAM : ACT_BIGRAM);
         p = pair_total == 0 ? 0 : $urandom_range(0, pair_total - 1);
         w.one_back = pair_owner[p] == TABLE_WORDS ? cfg_start_id : 16'(pair_owner[p]);
         if ($urandom_range(3) == 0) w.one_back = 16'($urandom_range(0, TABLE_WORDS + 2));
         if ($urandom_range(9) == 0) w.one_back = 16'($urandom);
         if ($urandom_range(9) < 7) w.current = pair_word[p];
         if (w.action == ACT_TRIGRAM) begin
            w.two_back = w.one_back;
            w.one_back = w.current;
            w.current = 16'($urandom);
            if ($urandom_range(9) < 7 && tri_start_ok[p] && tri_start[p] < TRI_DEPTH) begin
               k = tri_start[p] + $urandom_range(0, 2);
               if (k < TRI_DEPTH && tri_ok[k]) w.current = tri_word[k];
            end
         end
         bad = 1'b0;
         scratch = predict_answer(w, bad);
         if (!bad) begin
            send_word(w);
            return;
         end
      end
      send_word(make_word(ACT_SPARE_A));
   endtask

   task automatic random_run(input int unsigned count);
      repeat (count) random_item();
   endtask

   task automatic test_reset_state;
      query(ACT_BIGRAM, 16'h0000, 16'hFFFF, 16'h0000);
      query(ACT_TRIGRAM, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_word(make_word(ACT_SPARE_A));
      send_word(make_word(ACT_SPARE_B));
      query(ACT_BIGRAM, 16'h1234, 16'h0000, 16'hFFFF);
   endtask

   task automatic test_sorted_table;
      drain();
      build_table(TABLE_WORDS);
      write_reg(REG_WORD_COUNT, TABLE_WORDS);
      write_reg(REG_SUCC_COUNT, pair_total);
      write_reg(REG_TRI_COUNT, triple_total);
      write_reg(REG_START_ID, 32'hFFFF);
      load_entry(ACT_PAIR_START, PAIR_START_DEPTH, 16'hFFFF, 8'hFF);
      load_entry(ACT_PAIR_ENTRY, PAIR_DEPTH, 16'hFFFF, 8'hFF);
      load_entry(ACT_TRI_START, TRI_START_DEPTH, 16'hFFFF, 8'hFF);
      load_entry(ACT_TRI_ENTRY, 32'h7FFF, 16'hFFFF, 8'hFF);
      load_entry(ACT_PAIR_ENTRY, pair_total - 1, 16'hFFFF, 8'hFF);
      query(ACT_BIGRAM, 16'h0000, 16'hFFFF, 16'hFFFF);
      query(ACT_BIGRAM, 16'h0000, 16'hFFFF, pair_word[0]);
      query(ACT_BIGRAM, 16'h0000, 16'(TABLE_WORDS + 1), 16'h0000);
      query(ACT_BIGRAM, 16'h0000, 16'(TABLE_WORDS), 16'h0000);
      query(ACT_BIGRAM, 16'hFFFF, 16'(pair_owner[0]), pair_word[0]);
      query(ACT_TRIGRAM, 16'(pair_owner[0]), pair_word[0], tri_word[0]);
      query(ACT_TRIGRAM, 16'h0000, 16'h0000, 16'hFFFF);
      send_word(make_word(ACT_SPARE_B));
      quiet = 1'b1;
      random_run(150);
      quiet = 1'b0;
      random_run(200);
   endtask

   task automatic test_saturated_counts;
      lookup_word_type w;
      int unsigned     first_pos;
      bit              bad;
      answer_type      scratch;
      drain();
      load_entry(ACT_PAIR_START, WORD_LIMIT, pair_start[2], 8'd0);
      load_entry(ACT_PAIR_START, WORD_LIMIT + 1, pair_start[3], 8'd0);
      drain();
      write_reg(REG_WORD_COUNT, 32'h1FFF);
      write_reg(REG_SUCC_COUNT, 32'h7FFF);
      write_reg(REG_TRI_COUNT, 32'h7FFF);
      write_reg(REG_START_ID, 32'h0000);
      first_pos = pair_start[2];
      if (first_pos < PAIR_DEPTH && pair_ok[first_pos]) begin
         w = make_word(ACT_BIGRAM);
         w.one_back = 16'h0000;
         w.current = pair_word[first_pos];
         bad = 1'b0;
         scratch = predict_answer(w, bad);
         if (!bad) send_word(w);
      end
      random_run(280);
   endtask

   task automatic test_clamped_counts;
      drain();
      write_reg(REG_WORD_COUNT, TABLE_WORDS);
      write_reg(REG_SUCC_COUNT, pair_total / 2);
      write_reg(REG_TRI_COUNT, triple_total / 2);
      write_reg(REG_START_ID, $urandom_range(0, TABLE_WORDS + 4));
      random_run(250);
   endtask

   task automatic test_trigram_off;
      drain();
      write_reg(REG_SUCC_COUNT, pair_total);
      write_reg(REG_TRI_COUNT, 32'h0000);
      write_reg(REG_START_ID, 32'hFFFF);
      random_run(100);
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word: found=%0b value=%0d",
                                           rsp_found, rsp_value_byte);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_found !== want.found || rsp_value_byte !== want.value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected found=%0b value=%0d, got found=%0b value=%0d",
                           want.found, want.value, rsp_found, rsp_value_byte);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_psel) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[ngram_sorted_run_lookup] ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_action = ACT_SPARE_A;
      req_load_index = '0;
      req_load_data = '0;
      req_load_value = '0;
      req_word_two_back = '0;
      req_word_one_back = '0;
      req_word_current = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_words = 0;
      cfg_succ = 0;
      cfg_tri = 0;
      cfg_start_id = 16'hFFFF;
      pair_total = 0;
      triple_total = 0;
      mismatches = 0;
      stall_cycles = 0;
      quiet = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_sorted_table();
      test_saturated_counts();
      test_clamped_counts();
      test_trigram_off();
      drain();
      if (mismatches == 0) begin
         $display("[ngram_sorted_run_lookup] OK");
      end else begin
         $display("[ngram_sorted_run_lookup] ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
src/ngsr_pkg.sv
src/ngsr_ram.sv
src/ngsr_csr.sv
src/ngsr_dp.sv
src/ngsr_ctrl.sv
src/ngram_sorted_run_lookup.sv
tb/ngram_sorted_run_lookup_test.sv
